// ===== hdl/usfc_pkg.sv =====
// ----------------------------------------------------------------------------
// usfc_pkg
// Shared types, constants and the CRC-32/MPEG-2 byte update for the
// update-section framer.
// ----------------------------------------------------------------------------
`default_nettype none

package usfc_pkg;

    localparam logic [31:0] CRC_POLY  = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [7:0]  SYNC_HI   = 8'h77;
    localparam logic [7:0]  SYNC_LO   = 8'h6B;
    localparam logic [7:0]  PAD_BYTE  = 8'hFF;
    localparam logic [15:0] INFO_LEN  = 16'd24;
    localparam logic [15:0] OVERHEAD  = 16'd12;
    localparam int          JOB_DEPTH = 4;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_PAYLOAD = 2'd1,
        CMD_FILL    = 2'd2,
        CMD_INFO    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_TOTAL = 2'd0,
        REG_CHIP  = 2'd1,
        REG_HW    = 2'd2,
        REG_SW    = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        JOB_HDR   = 3'd0,
        JOB_PAY   = 3'd1,
        JOB_FILL  = 3'd2,
        JOB_INFO  = 3'd3,
        JOB_FAULT = 3'd4
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic        trail;    // append the CRC trailer after this job
        logic [7:0]  data;
        logic [15:0] num;
        logic [15:0] len;
    } t_job;

    typedef struct packed {
        logic [15:0] total;
        logic [31:0] chip_id;
        logic [31:0] hw_rev;
        logic [31:0] sw_rev;
    } t_cfg;

    // MSB-first CRC-32 update over one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {b, 24'd0};
        for (int k = 0; k < 8; k++) begin
            if (c[31]) begin
                c = {c[30:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[30:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/usfc_job_fifo.sv =====
// ----------------------------------------------------------------------------
// usfc_job_fifo
// Short job queue between the command front end and the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module usfc_job_fifo
    import usfc_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  t_job i_job,
    output logic o_full,
    input  wire  i_pop,
    output t_job o_job,
    output logic o_empty
);

    localparam int AW = $clog2(JOB_DEPTH);

    t_job               r_mem [JOB_DEPTH];
    logic [AW-1:0]      r_wr_ptr;
    logic [AW-1:0]      r_rd_ptr;
    logic [AW:0]        r_count;

    logic               w_push;
    logic               w_pop;

    assign o_full  = (r_count == (AW+1)'(JOB_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + (AW+1)'(1);
                2'b01:   r_count <= r_count - (AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/usfc_front.sv =====
// ----------------------------------------------------------------------------
// usfc_front
// Command front end: tracks section and slot state, turns each word into
// one job for the byte sequencer (or none for an idle fill tick).
// ----------------------------------------------------------------------------
`default_nettype none

module usfc_front
    import usfc_pkg::*;
#(
    parameter int SLOT_BYTES = 900
)(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_accept,
    input  wire  [1:0]  i_command,
    input  wire  [7:0]  i_data_byte,
    input  wire  [15:0] i_sec_num,
    input  wire  [9:0]  i_payload_length,
    output logic        o_push,
    output t_job        o_job
);

    localparam int          SW     = $clog2(SLOT_BYTES + 1);
    localparam logic [16:0] SAT    = 17'(SLOT_BYTES - 12);
    localparam logic [SW-1:0] FULL = SW'(SLOT_BYTES);

    logic          r_open, n_open;
    logic [9:0]    r_left, n_left;
    logic [SW-1:0] r_slot, n_slot;

    logic [9:0]    w_plen;
    logic          w_last_pay;

    // clamp the payload to what fits in the slot
    assign w_plen     = ({7'd0, i_payload_length} > SAT) ? SAT[9:0] : i_payload_length;
    assign w_last_pay = (r_left == 10'd1);

    always_comb begin
        n_open = r_open;
        n_left = r_left;
        n_slot = r_slot;
        o_push = 1'b0;
        o_job  = '{kind: JOB_FILL, trail: 1'b0, data: i_data_byte,
                   num: i_sec_num, len: 16'(w_plen) + OVERHEAD};
        if (i_accept) begin
            case (t_cmd'(i_command))
                CMD_START: begin
                    o_push      = 1'b1;
                    o_job.kind  = JOB_HDR;
                    o_job.trail = (w_plen == 10'd0);
                    n_open      = (w_plen != 10'd0);
                    n_left      = w_plen;
                    n_slot      = (w_plen == 10'd0) ? SW'(12) : SW'(8);
                end
                CMD_PAYLOAD: begin
                    o_push = 1'b1;
                    if (!r_open) begin
                        o_job.kind = JOB_FAULT;
                    end else begin
                        o_job.kind  = JOB_PAY;
                        o_job.trail = w_last_pay;
                        n_left      = r_left - 10'd1;
                        n_open      = !w_last_pay;
                        n_slot      = r_slot + (w_last_pay ? SW'(5) : SW'(1));
                    end
                end
                CMD_FILL: begin
                    if (!r_open && r_slot < FULL) begin
                        o_push     = 1'b1;
                        o_job.kind = JOB_FILL;
                        n_slot     = r_slot + SW'(1);
                    end
                end
                CMD_INFO: begin
                    o_push     = 1'b1;
                    o_job.kind = JOB_INFO;
                    n_open     = 1'b0;
                    n_left     = 10'd0;
                    n_slot     = SW'(24);
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= 10'd0;
            r_slot <= FULL;
        end else begin
            r_open <= n_open;
            r_left <= n_left;
            r_slot <= n_slot;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/usfc_back.sv =====
// ----------------------------------------------------------------------------
// usfc_back
// Byte sequencer: expands each job into slot bytes, runs the CRC and
// drives the registered output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module usfc_back
    import usfc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cfg        i_cfg,
    input  t_job        i_job,
    input  wire         i_empty,
    output logic        o_pop,
    output logic        o_tvalid,
    input  wire         i_tready,
    output logic [7:0]  o_tdata,
    output logic        o_tlast,
    output logic        o_fault
);

    t_job        r_job;
    logic        r_busy;
    logic [4:0]  r_idx;
    logic [31:0] r_crc;
    logic        r_tvalid;
    logic [7:0]  r_tdata;
    logic        r_tlast;
    logic        r_fault;

    logic        w_step;
    logic        w_last;
    logic        w_load;
    logic [4:0]  w_final;
    logic        w_in_trail;
    logic [4:0]  w_tstart;
    logic [4:0]  w_tofs;
    logic [7:0]  w_byte;
    logic        w_upd;
    logic        w_restart;
    logic        w_fault;
    logic [15:0] w_len;
    logic [15:0] w_num;
    logic [31:0] w_word;
    logic [31:0] w_crc_next;

    assign w_step = r_busy && (!r_tvalid || i_tready);
    assign w_last = (r_idx == w_final);
    assign w_load = !r_busy || (w_step && w_last);
    assign o_pop  = w_load && !i_empty;

    assign w_len  = (r_job.kind == JOB_INFO) ? INFO_LEN : r_job.len;
    assign w_num  = (r_job.kind == JOB_INFO) ? 16'd0 : r_job.num;
    assign w_tofs = r_idx - w_tstart;

    // info section words sit at bytes 8..19
    always_comb begin
        case (r_idx[4:2])
            3'd2:    w_word = i_cfg.chip_id;
            3'd3:    w_word = i_cfg.hw_rev;
            default: w_word = i_cfg.sw_rev;
        endcase
    end

    always_comb begin
        case (r_job.kind)
            JOB_HDR: begin
                w_final  = r_job.trail ? 5'd11 : 5'd7;
                w_tstart = 5'd8;
            end
            JOB_PAY: begin
                w_final  = r_job.trail ? 5'd4 : 5'd0;
                w_tstart = 5'd1;
            end
            JOB_INFO: begin
                w_final  = 5'd23;
                w_tstart = 5'd20;
            end
            default: begin
                w_final  = 5'd0;
                w_tstart = 5'd1;
            end
        endcase
    end

    assign w_in_trail = (r_job.kind == JOB_HDR || r_job.kind == JOB_PAY ||
                         r_job.kind == JOB_INFO) && (r_idx >= w_tstart);

    always_comb begin
        w_byte    = 8'd0;
        w_upd     = 1'b0;
        w_restart = 1'b0;
        w_fault   = 1'b0;
        if (w_in_trail) begin
            case (w_tofs[1:0])
                2'd0:    w_byte = r_crc[31:24];
                2'd1:    w_byte = r_crc[23:16];
                2'd2:    w_byte = r_crc[15:8];
                default: w_byte = r_crc[7:0];
            endcase
        end else begin
            case (r_job.kind)
                JOB_HDR, JOB_INFO: begin
                    case (r_idx)
                        5'd0: begin
                            w_byte    = SYNC_HI;
                            w_restart = 1'b1;
                        end
                        5'd1:    w_byte = SYNC_LO;
                        5'd2:    w_byte = w_len[15:8];
                        5'd3:    w_byte = w_len[7:0];
                        5'd4:    w_byte = w_num[15:8];
                        5'd5:    w_byte = w_num[7:0];
                        5'd6:    w_byte = i_cfg.total[15:8];
                        5'd7:    w_byte = i_cfg.total[7:0];
                        default: begin
                            case (r_idx[1:0])
                                2'd0:    w_byte = w_word[31:24];
                                2'd1:    w_byte = w_word[23:16];
                                2'd2:    w_byte = w_word[15:8];
                                default: w_byte = w_word[7:0];
                            endcase
                        end
                    endcase
                    w_upd = (r_idx >= 5'd4);
                end
                JOB_PAY: begin
                    w_byte = r_job.data;
                    w_upd  = 1'b1;
                end
                JOB_FILL: begin
                    w_byte = PAD_BYTE;
                end
                JOB_FAULT: begin
                    w_fault = 1'b1;
                end
                default: begin
                    w_byte = 8'd0;
                end
            endcase
        end
    end

    assign w_crc_next = crc_byte(r_crc, w_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= 5'd0;
            r_crc    <= CRC_INIT;
            r_tvalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= !i_empty;
                r_idx  <= 5'd0;
            end else if (w_step) begin
                r_idx  <= r_idx + 5'd1;
            end
            if (w_step) begin
                if (w_restart) begin
                    r_crc <= CRC_INIT;
                end else if (w_upd) begin
                    r_crc <= w_crc_next;
                end
                r_tvalid <= 1'b1;
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && !i_empty) begin
            r_job <= i_job;
        end
        if (w_step) begin
            r_tdata <= w_byte;
            r_tlast <= w_last;
            r_fault <= w_fault;
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;
    assign o_fault  = r_fault;

endmodule

`default_nettype wire

// ===== hdl/update_section_framer_crc32_unit.sv =====
// ----------------------------------------------------------------------------
// update_section_framer_crc32_unit
// Frames update sections into fixed slots with a CRC-32/MPEG-2 trailer.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle out of the sequencer while the output is not stalled;
//   a payload or fill word yields 1 byte, a start 8 (12 with empty payload), a last payload 5, info 24.
// A four-entry job queue lets input words keep arriving while bytes drain.
// Reset (synchronous, active low): slot full, no section open, CRC all ones,
//   total_sections 0, chip id and both revision registers 1, queue and output empty.
`default_nettype none

module update_section_framer_crc32_unit
    import usfc_pkg::*;
#(
    parameter int SLOT_BYTES = 900
)(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    // command stream
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [39:0] i_s_axis_tdata,   // data_byte[7:0], sec_num[23:8],
                                          // payload_length[33:24], zero[39:34]
    input  wire  [1:0]  i_s_axis_tuser,   // command[1:0]
    // slot byte stream
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // out_byte[7:0]
    output logic        o_m_axis_tlast,   // run_last
    output logic        o_m_axis_tuser    // fault[0]
);

    t_cfg r_cfg;
    t_job w_job_in;
    t_job w_job_out;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    logic w_accept;

    assign o_s_axis_tready = !w_full;
    assign w_accept        = i_s_axis_tvalid && !w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.total   <= 16'd0;
            r_cfg.chip_id <= 32'd1;
            r_cfg.hw_rev  <= 32'd1;
            r_cfg.sw_rev  <= 32'd1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_TOTAL: r_cfg.total   <= i_cfg_data[15:0];
                REG_CHIP:  r_cfg.chip_id <= i_cfg_data;
                REG_HW:    r_cfg.hw_rev  <= i_cfg_data;
                REG_SW:    r_cfg.sw_rev  <= i_cfg_data;
                default:   r_cfg         <= r_cfg;
            endcase
        end
    end

    usfc_front #(
        .SLOT_BYTES (SLOT_BYTES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_command        (i_s_axis_tuser),
        .i_data_byte      (i_s_axis_tdata[7:0]),
        .i_sec_num        (i_s_axis_tdata[23:8]),
        .i_payload_length (i_s_axis_tdata[33:24]),
        .o_push           (w_push),
        .o_job            (w_job_in)
    );

    usfc_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_empty (w_empty)
    );

    usfc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_job    (w_job_out),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast),
        .o_fault  (o_m_axis_tuser)
    );

endmodule

`default_nettype wire
